@@ sv/bfsc_pkg.sv @@
// Package for the bitmap find/set/clear block.
// Types, codes and helpers shared by the top level and the word search unit.
// No dependencies.
package bfsc_pkg;

  localparam int MAP_BYTES_DEF  = 64;
  localparam int BYTES_PER_WORD = 4;
  localparam int WORD_W         = 32;
  localparam int LEN_W          = 7;
  localparam int IDX_W          = 9;
  localparam int CMD_W          = 3;
  localparam int WCNT_W         = 6;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [PADDR_W-1:0] ADDR_BYTES_IN_USE = 3'd0;
  localparam logic [LEN_W-1:0]   BYTES_IN_USE_RST  = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR_ALL  = 3'd0,
    CMD_FIND_ZERO  = 3'd1,
    CMD_FIND_ONE   = 3'd2,
    CMD_SET_BIT    = 3'd3,
    CMD_CLEAR_BIT  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_FIND,
    S_RMW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } search_t;

  // Byte lanes of word w that lie below the length in use
  function automatic logic [BYTES_PER_WORD-1:0] word_bytes_in_use(
    input logic [WCNT_W-1:0] w,
    input logic [LEN_W-1:0]  len
  );
    logic [BYTES_PER_WORD-1:0] m;
    m = '0;
    for (int j = 0; j < BYTES_PER_WORD; j++) begin
      m[j] = ({w, 2'(j)} < {1'b0, len});
    end
    return m;
  endfunction

endpackage

@@ sv/bfsc_in_if.sv @@
// Command channel: valid/ready handshake carrying one command word.
// Depends on bfsc_pkg for field widths.
interface bfsc_in_if import bfsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] bit_index;

  modport source (output valid, output cmd, output bit_index, input ready);
  modport sink   (input valid, input cmd, input bit_index, output ready);
endinterface

@@ sv/bfsc_out_if.sv @@
// Result channel: valid/ready handshake carrying one result word.
// Depends on bfsc_pkg for field widths.
interface bfsc_out_if import bfsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] found_index;

  modport source (output valid, output found, output found_index, input ready);
  modport sink   (input valid, input found, input found_index, output ready);
endinterface

@@ sv/bfsc_word_search.sv @@
// Lowest-bit search over one map word, limited to the bytes in use.
// Depends on bfsc_pkg.
module bfsc_word_search import bfsc_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  logic              want,
  input  logic [WCNT_W-1:0] word_num,
  input  logic [LEN_W-1:0]  len,
  output search_t           res
);

  logic [BYTES_PER_WORD-1:0] lanes;
  logic [WORD_W-1:0]         vec;
  logic [4:0]                pos;

  always_comb begin
    lanes = word_bytes_in_use(word_num, len);
    vec   = want ? word : ~word;
    for (int j = 0; j < BYTES_PER_WORD; j++) begin
      if (!lanes[j]) vec[8*j +: 8] = 8'h00;
    end
    pos = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (vec[k]) pos = 5'(k);
    end
    res.hit = |vec;
    res.idx = IDX_W'({word_num, pos});
  end

endmodule

@@ sv/bitmap_find_set_clear.sv @@
// Bitmap allocator: clear all, find first zero/one, set bit, clear bit.
// One command at a time, one 32-bit map word per memory access. Find reads the words in use
// until the first hit, clear all writes each word in use, in-range set/clear bit reads and
// writes back one word. Next command taken as the result shows (later if one waits unread).
// Reset: synchronous; a sweep zeroes all ceil(MAP_BYTES/4) map words, commands held off.
// Depends on bfsc_pkg, bfsc_in_if, bfsc_out_if, bfsc_word_search.
module bitmap_find_set_clear import bfsc_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bfsc_in_if.sink            in_ch,
  bfsc_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  localparam int WORDS = (MAP_BYTES + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  // configuration
  logic [LEN_W-1:0]  bytes_in_use_r;
  logic [LEN_W-1:0]  len;
  logic [WCNT_W-1:0] nw;
  logic [WCNT_W-1:0] nw_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_use_r <= BYTES_IN_USE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_BYTES_IN_USE) begin
      bytes_in_use_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_BYTES_IN_USE) ? PDATA_W'(bytes_in_use_r) : '0;

  assign len     = ({25'd0, bytes_in_use_r} > 32'(MAP_BYTES)) ? LEN_W'(MAP_BYTES)
                                                                : bytes_in_use_r;
  assign nw      = WCNT_W'(({1'b0, len} + 8'd3) >> 2);
  assign nw_last = WCNT_W'(nw - 6'd1);

  // map memory
  logic [WORD_W-1:0]         mem [WORDS];
  logic [WORD_W-1:0]         rd_data_r;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [BYTES_PER_WORD-1:0] mem_wbe;
  logic [WORD_W-1:0]         mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int j = 0; j < BYTES_PER_WORD; j++) begin
        if (mem_wbe[j]) mem[mem_waddr][8*j +: 8] <= mem_wdata[8*j +: 8];
      end
    end
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // control
  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WCNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [AW-1:0]     init_cnt_r, init_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [WCNT_W-1:0] rd_word_r, rd_word_nxt;
  logic              res_found_r, res_found_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              in_acc;
  logic [AW-1:0]     scan_addr;
  logic [AW-1:0]     in_word_addr;
  logic [AW-1:0]     rmw_addr;
  logic              in_byte_ok;
  logic [WORD_W-1:0] bit_mask;
  search_t           srch;

  bfsc_word_search u_search (
    .word     (rd_data_r),
    .want     (cmd_r == CMD_FIND_ONE),
    .word_num (rd_word_r),
    .len      (len),
    .res      (srch)
  );

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign scan_addr    = AW'({{AW{1'b0}}, iss_cnt_r});
  assign in_word_addr = AW'({{AW{1'b0}}, in_ch.bit_index[IDX_W-1:5]});
  assign rmw_addr     = AW'({{AW{1'b0}}, idx_r[IDX_W-1:5]});
  assign in_byte_ok   = ({2'b00, in_ch.bit_index[IDX_W-1:3]} < {1'b0, len});
  assign bit_mask     = WORD_W'(1) << idx_r[4:0];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    iss_cnt_nxt   = iss_cnt_r;
    init_cnt_nxt  = init_cnt_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    in_ch.ready   = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = scan_addr;
    mem_we        = 1'b0;
    mem_waddr     = scan_addr;
    mem_wbe       = '0;
    mem_wdata     = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_INIT: begin
        mem_we       = 1'b1;
        mem_waddr    = init_cnt_r;
        mem_wbe      = '1;
        init_cnt_nxt = AW'(init_cnt_r + 1'b1);
        if (init_cnt_r == AW'(WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          cmd_nxt       = in_ch.cmd;
          idx_nxt       = in_ch.bit_index;
          iss_cnt_nxt   = '0;
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          unique case (in_ch.cmd)
            CMD_CLEAR_ALL: state_nxt = (nw == '0) ? S_DONE : S_CLR;
            CMD_FIND_ZERO,
            CMD_FIND_ONE:  state_nxt = (nw == '0) ? S_DONE : S_FIND;
            CMD_SET_BIT,
            CMD_CLEAR_BIT: begin
              if (in_byte_ok) begin
                mem_re    = 1'b1;
                mem_raddr = in_word_addr;
                state_nxt = S_RMW;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default:       state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        mem_we      = 1'b1;
        mem_wbe     = word_bytes_in_use(iss_cnt_r, len);
        iss_cnt_nxt = WCNT_W'(iss_cnt_r + 1'b1);
        if (iss_cnt_r == nw_last) state_nxt = S_DONE;
      end
      S_FIND: begin
        if (iss_cnt_r < nw) begin
          mem_re      = 1'b1;
          iss_cnt_nxt = WCNT_W'(iss_cnt_r + 1'b1);
        end
        if (rd_vld_r) begin
          if (srch.hit) begin
            res_found_nxt = 1'b1;
            res_idx_nxt   = srch.idx;
            state_nxt     = S_DONE;
          end else if (rd_word_r == nw_last) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = rmw_addr;
        mem_wbe   = '1;
        mem_wdata = (cmd_r == CMD_SET_BIT) ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rd_vld_nxt  = mem_re && (state_r == S_FIND);
  assign rd_word_nxt = iss_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      iss_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    rd_word_r   <= rd_word_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.found_index = out_idx_r;

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIND |-> iss_cnt_r <= nw)
    else $error("find scan issued beyond the words in use");

  a_miss_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.found_index == '0)
    else $error("result without a hit carries a nonzero index");

  a_rmw_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_byte_ok &&
    (in_ch.cmd == CMD_SET_BIT || in_ch.cmd == CMD_CLEAR_BIT) |=> state_r == S_RMW)
    else $error("in-range set/clear did not enter write-back");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for bitmap_find_set_clear: directed and random command words,
// predicted against a shadow copy of the allocation map and of bytes_in_use.
// Depends on bfsc_pkg, bfsc_in_if, bfsc_out_if and the block itself.
module testbench import bfsc_pkg::*; ();

  localparam logic [CMD_W-1:0] FIRST_SPARE_CMD = CMD_W'(CMD_CLEAR_BIT + 1);
  localparam logic [CMD_W-1:0] LAST_SPARE_CMD  = '1;

  // Shadow allocation map and the answers it predicts
  class alloc_map_tracker;
    logic [7:0]       map_q [MAP_BYTES_DEF];
    logic [LEN_W-1:0] len_q;
    search_t          answers_due [$];
    int               errors;

    function new();
      foreach (map_q[b]) map_q[b] = '0;
      len_q  = BYTES_IN_USE_RST;
      errors = 0;
    endfunction

    function int unsigned active_bytes();
      return (len_q > MAP_BYTES_DEF) ? MAP_BYTES_DEF : len_q;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      len_q = v;
    endfunction

    function int unsigned due();
      return answers_due.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function search_t lowest(logic want);
      search_t     s;
      int unsigned n;
      s = '0;
      n = active_bytes() * 8;
      for (int unsigned k = 0; k < n; k++) begin
        if (map_q[k / 8][k % 8] == want) begin
          s.hit = 1'b1;
          s.idx = IDX_W'(k);
          return s;
        end
      end
      return s;
    endfunction

    function void note_command(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i);
      search_t     a;
      int unsigned n;
      int unsigned b;
      a = '0;
      n = active_bytes();
      b = i >> 3;
      case (c)
        CMD_CLEAR_ALL: begin
          for (int unsigned k = 0; k < n; k++) map_q[k] = '0;
        end
        CMD_FIND_ZERO: a = lowest(1'b0);
        CMD_FIND_ONE:  a = lowest(1'b1);
        CMD_SET_BIT: begin
          if (b < n) map_q[b][i[2:0]] = 1'b1;
        end
        CMD_CLEAR_BIT: begin
          if (b < n) map_q[b][i[2:0]] = 1'b0;
        end
        default: ;
      endcase
      answers_due.push_back(a);
    endfunction

    function void check_answer(logic found, logic [IDX_W-1:0] idx);
      search_t e;
      if (answers_due.size() == 0) begin
        flag($sformatf("unexpected result word: found %0d found_index %0d", found, idx));
        return;
      end
      e = answers_due.pop_front();
      if (found !== e.hit)
        flag($sformatf("found: expected %0d, got %0d", e.hit, found));
      if (idx !== e.idx)
        flag($sformatf("found_index: expected %0d, got %0d", e.idx, idx));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  bfsc_in_if  in_ch ();
  bfsc_out_if out_ch ();

  alloc_map_tracker tracker = new();
  int idle_pct;
  int stall_pct;
  int fill_next;

  bitmap_find_set_clear uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random back-pressure bursts
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        tracker.check_answer(out_ch.found, out_ch.found_index);
      if (hold > 0) hold--;
      else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        hold = $urandom_range(1, 7);
      out_ch.ready <= (hold == 0);
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] i);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.bit_index <= i;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_command(c, i);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_answered();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.due() != 0);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    wait_all_answered();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_BYTES_IN_USE;
    cfg_pwdata  <= PDATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    tracker.set_length(v);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== PDATA_W'(v))
      tracker.flag($sformatf("bytes_in_use read: expected %0d, got %0d", v, cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int unsigned bits);
    int r;
    r = $urandom_range(0, 7);
    if (bits == 0 || r == 0) return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    if (r == 1) return IDX_W'(bits + $urandom_range(0, 7));
    return IDX_W'($urandom_range(0, bits - 1));
  endfunction

  task automatic random_words(input int budget, input bit pause_midway);
    int          sent;
    int          r;
    int          k;
    int unsigned bits;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < budget) begin
      bits = tracker.active_bytes() * 8;
      r    = $urandom_range(0, 99);
      if (pause_midway && !paused && sent >= budget / 2) begin
        wait_all_answered();
        paused = 1'b1;
      end
      if (r < 25 && bits != 0) begin
        // run of consecutive sets, then probe both searches
        k = $urandom_range(1, 16);
        repeat (k) begin
          send_command(CMD_SET_BIT, IDX_W'(fill_next % bits));
          fill_next++;
        end
        send_command(CMD_FIND_ZERO, pick_index(bits));
        send_command(CMD_FIND_ONE, pick_index(bits));
        sent += k + 2;
      end else begin
        if (r < 50)      send_command(CMD_SET_BIT, pick_index(bits));
        else if (r < 65) send_command(CMD_CLEAR_BIT, pick_index(bits));
        else if (r < 78) send_command(CMD_FIND_ZERO, pick_index(bits));
        else if (r < 91) send_command(CMD_FIND_ONE, pick_index(bits));
        else if (r < 94) begin
          send_command(CMD_CLEAR_ALL, pick_index(bits));
          fill_next = $urandom_range(0, 1) ? 0 : $urandom_range(0, 511);
        end else
          send_command(CMD_W'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD)),
                       pick_index(bits));
        sent++;
      end
    end
  endtask

  initial begin
    logic [LEN_W-1:0] phase_len [14];
    int               pct_choice [3];
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_CLEAR_ALL;
    in_ch.bit_index <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= ADDR_BYTES_IN_USE;
    cfg_pwdata      <= '0;
    rst_n           <= 1'b0;
    idle_pct   = 20;
    stall_pct  = 20;
    fill_next  = 0;
    pct_choice = '{0, 15, 40};
    phase_len  = '{7'd0, 7'd3, 7'd1, 7'd127, 7'd5, 7'd2, 7'd64, 7'd8, 7'd65, 7'd16, 7'd63,
                   7'd4, 7'd0, 7'd0};
    phase_len[12] = LEN_W'($urandom_range(1, 127));
    phase_len[13] = LEN_W'($urandom_range(1, 12));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty map, top and bottom bits, spare codes, at the reset length
    send_command(CMD_FIND_ZERO, '1);
    send_command(CMD_FIND_ONE, '0);
    send_command(CMD_SET_BIT, 9'd511);
    send_command(CMD_FIND_ONE, '0);
    send_command(CMD_SET_BIT, 9'd0);
    send_command(CMD_FIND_ONE, '0);
    send_command(CMD_CLEAR_BIT, 9'd0);
    send_command(CMD_FIND_ONE, '0);
    send_command(CMD_SET_BIT, 9'd256);
    send_command(CMD_CLEAR_BIT, 9'd511);
    send_command(CMD_FIND_ONE, '0);
    send_command(CMD_CLEAR_ALL, '1);
    send_command(CMD_FIND_ONE, '0);
    send_command(LAST_SPARE_CMD, 9'd511);
    send_command(FIRST_SPARE_CMD, 9'd0);

    // one byte in use: fill it, search a full map, write past the end
    write_length(7'd1);
    for (int b = 0; b < 8; b++) send_command(CMD_SET_BIT, IDX_W'(b));
    send_command(CMD_FIND_ZERO, '0);
    send_command(CMD_SET_BIT, 9'd8);
    send_command(CMD_FIND_ONE, '0);

    foreach (phase_len[p]) begin
      write_length(phase_len[p]);
      if (p >= 12) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = pct_choice[$urandom_range(0, 2)];
        stall_pct = pct_choice[$urandom_range(0, 2)];
      end
      fill_next = 0;
      random_words(118, p == 3);
    end

    wait_all_answered();
    repeat (30) @(posedge clk);
    if (tracker.errors == 0 && tracker.due() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bfsc_pkg.sv
sv/bfsc_in_if.sv
sv/bfsc_out_if.sv
sv/bfsc_word_search.sv
sv/bitmap_find_set_clear.sv
dv/testbench.sv
